FILE: rtl/point_box_contact_defines.svh
// ----------------------------------------------------------------------------
// point_box_contact_defines
// Assertion macros shared by the checker of the point-in-box contact block.
// ----------------------------------------------------------------------------
`ifndef POINT_BOX_CONTACT_DEFINES_SVH
`define POINT_BOX_CONTACT_DEFINES_SVH

// Antecedent in this cycle implies consequent in the same cycle.
`define PBC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("point_box_contact check failed");

// Antecedent in this cycle implies consequent in the next cycle.
`define PBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("point_box_contact check failed");

`endif

FILE: rtl/pbc_pkg.sv
// ----------------------------------------------------------------------------
// pbc_pkg
// Types and constants of the point-in-box nearest-face contact pipeline.
// ----------------------------------------------------------------------------
package pbc_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned SizeW  = 31;
  localparam int unsigned NAxes  = 3;

  // configuration register indexes
  localparam logic [2:0] REG_BOX_MIN_X  = 3'd0;
  localparam logic [2:0] REG_BOX_MIN_Y  = 3'd1;
  localparam logic [2:0] REG_BOX_MIN_Z  = 3'd2;
  localparam logic [2:0] REG_BOX_SIZE_X = 3'd3;
  localparam logic [2:0] REG_BOX_SIZE_Y = 3'd4;
  localparam logic [2:0] REG_BOX_SIZE_Z = 3'd5;

  // axis positions in the coordinate vectors
  localparam int unsigned AXIS_X = 0;
  localparam int unsigned AXIS_Y = 1;
  localparam int unsigned AXIS_Z = 2;

  // normal component codes
  localparam logic [1:0] NORM_ZERO = 2'b00;
  localparam logic [1:0] NORM_POS  = 2'b01;
  localparam logic [1:0] NORM_NEG  = 2'b11;

  localparam logic [CoordW-1:0] COORD_MAX = {1'b0, {(CoordW-1){1'b1}}};

  typedef logic [NAxes-1:0][CoordW-1:0] vec3_t;
  typedef logic [NAxes-1:0][SizeW-1:0]  size3_t;

  typedef struct packed {
    vec3_t  min;
    size3_t size;
  } box_t;

  // after stage 1: point and signed distance to the minimum corner
  typedef struct packed {
    vec3_t                      p;
    logic [NAxes-1:0][CoordW:0] dmin;
  } s1_t;

  // after stage 2: inside flag and both face distances (valid when inside)
  typedef struct packed {
    vec3_t  p;
    logic   in_box;
    size3_t dmin;
    size3_t dplus;
  } s2_t;

  // after stage 3: nearer face on each axis and its distance
  typedef struct packed {
    vec3_t            p;
    logic             in_box;
    logic [NAxes-1:0] plus;
    size3_t           face_dist;
  } s3_t;

  typedef struct packed {
    logic                  hit;
    vec3_t                 contact;
    logic [NAxes-1:0][1:0] normal;
  } res_t;

endpackage

FILE: rtl/pbc_dist.sv
// ----------------------------------------------------------------------------
// pbc_dist
// Stages 1 and 2: distances to the minimum and maximum faces, inside test.
// ----------------------------------------------------------------------------
module pbc_dist import pbc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  box_t  box_i,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  vec3_t in_point_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output s2_t   out_data_o
);

  logic v1_q, v2_q;
  logic en1, en2;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;

  assign en2 = !v2_q || out_ready_i;
  assign en1 = !v1_q || en2;

  always_comb begin
    s1_d.p = in_point_i;
    for (int i = 0; i < NAxes; i++) begin
      s1_d.dmin[i] = {in_point_i[i][CoordW-1], in_point_i[i]}
                   - {box_i.min[i][CoordW-1], box_i.min[i]};
    end
  end

  always_comb begin
    logic [CoordW+1:0] dplus;
    logic              in_all;
    s2_d.p = s1_q.p;
    in_all = 1'b1;
    for (int i = 0; i < NAxes; i++) begin
      // distance to the far face is size minus distance to the near one
      dplus = {3'b000, box_i.size[i]} - {s1_q.dmin[i][CoordW], s1_q.dmin[i]};
      if (s1_q.dmin[i][CoordW] || dplus[CoordW+1]) begin
        in_all = 1'b0;
      end
      s2_d.dmin[i]  = s1_q.dmin[i][SizeW-1:0];
      s2_d.dplus[i] = dplus[SizeW-1:0];
    end
    s2_d.in_box = in_all;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_q <= s1_d;
    end
    if (en2) begin
      s2_q <= s2_d;
    end
  end

  assign in_ready_o  = en1;
  assign out_valid_o = v2_q;
  assign out_data_o  = s2_q;

endmodule

FILE: rtl/pbc_axis.sv
// ----------------------------------------------------------------------------
// pbc_axis
// Stage 3: pick the nearer of the two faces on each axis.
// ----------------------------------------------------------------------------
module pbc_axis import pbc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  s2_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output s3_t  out_data_o
);

  logic v_q;
  logic en;
  s3_t  s3_d, s3_q;

  assign en = !v_q || out_ready_i;

  always_comb begin
    s3_d.p      = in_data_i.p;
    s3_d.in_box = in_data_i.in_box;
    // top before bottom and front before back win ties; left before right
    s3_d.plus[AXIS_Y] = in_data_i.dplus[AXIS_Y] <= in_data_i.dmin[AXIS_Y];
    s3_d.plus[AXIS_X] = in_data_i.dplus[AXIS_X] <  in_data_i.dmin[AXIS_X];
    s3_d.plus[AXIS_Z] = in_data_i.dplus[AXIS_Z] <= in_data_i.dmin[AXIS_Z];
    for (int i = 0; i < NAxes; i++) begin
      s3_d.face_dist[i] = s3_d.plus[i] ? in_data_i.dplus[i] : in_data_i.dmin[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q <= s3_d;
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = v_q;
  assign out_data_o  = s3_q;

endmodule

FILE: rtl/pbc_select.sv
// ----------------------------------------------------------------------------
// pbc_select
// Stage 4: choose the nearest face, project the point, register the result.
// ----------------------------------------------------------------------------
module pbc_select import pbc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  box_t box_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  s3_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  logic v_q;
  logic en;
  res_t res_d, res_q;

  assign en = !v_q || out_ready_i;

  always_comb begin
    logic [NAxes-1:0]  sel;
    logic [CoordW:0]   max_sum;
    logic [CoordW-1:0] face_val;
    logic              x_lt_y, z_lt_y, z_lt_x;
    x_lt_y = in_data_i.face_dist[AXIS_X] < in_data_i.face_dist[AXIS_Y];
    z_lt_y = in_data_i.face_dist[AXIS_Z] < in_data_i.face_dist[AXIS_Y];
    z_lt_x = in_data_i.face_dist[AXIS_Z] < in_data_i.face_dist[AXIS_X];
    // y faces first, then x, then z; a later face needs a strictly shorter distance
    sel         = '0;
    sel[AXIS_Y] = !x_lt_y && !z_lt_y;
    sel[AXIS_X] = x_lt_y && !z_lt_x;
    sel[AXIS_Z] = !sel[AXIS_Y] && !sel[AXIS_X];
    res_d.hit = in_data_i.in_box;
    for (int i = 0; i < NAxes; i++) begin
      max_sum = {box_i.min[i][CoordW-1], box_i.min[i]} + {2'b00, box_i.size[i]};
      if (in_data_i.plus[i]) begin
        // saturate the far face when it lies past the positive range
        face_val = (!max_sum[CoordW] && max_sum[CoordW-1]) ? COORD_MAX
                                                           : max_sum[CoordW-1:0];
      end else begin
        face_val = box_i.min[i];
      end
      if (!in_data_i.in_box) begin
        res_d.contact[i] = '0;
        res_d.normal[i]  = NORM_ZERO;
      end else if (sel[i]) begin
        res_d.contact[i] = face_val;
        res_d.normal[i]  = in_data_i.plus[i] ? NORM_POS : NORM_NEG;
      end else begin
        res_d.contact[i] = in_data_i.p[i];
        res_d.normal[i]  = NORM_ZERO;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = v_q;
  assign out_data_o  = res_q;

endmodule

FILE: rtl/point_box_contact.sv
// ----------------------------------------------------------------------------
// point_box_contact
// Point against axis-aligned box test with nearest-face contact and normal.
// ----------------------------------------------------------------------------
// Each input word is a point; each output word is hit, the contact point and
// the face normal. One word is accepted per clock while the pipe is not held,
// and it passes through the four register stages (near-face distance,
// far-face distance and inside test, per-axis face pick, final face pick and
// projection). A stall on the output holds the full stages from the output
// back to the first bubble; bubbles in the pipe still let new words in while a
// result waits. Write the box registers only while no word is in flight.
module point_box_contact import pbc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_addr_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // point_x, point_y, point_z
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata    // hit, contact_x/y/z, normal_x/y/z, pad
);

  box_t  box_q;
  vec3_t point;
  logic  d_valid, d_ready, a_valid, a_ready;
  s2_t   d_data;
  s3_t   a_data;
  res_t  res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_BOX_MIN_X:  box_q.min[AXIS_X]  <= cfg_wdata_i;
        REG_BOX_MIN_Y:  box_q.min[AXIS_Y]  <= cfg_wdata_i;
        REG_BOX_MIN_Z:  box_q.min[AXIS_Z]  <= cfg_wdata_i;
        REG_BOX_SIZE_X: box_q.size[AXIS_X] <= cfg_wdata_i[SizeW-1:0];
        REG_BOX_SIZE_Y: box_q.size[AXIS_Y] <= cfg_wdata_i[SizeW-1:0];
        REG_BOX_SIZE_Z: box_q.size[AXIS_Z] <= cfg_wdata_i[SizeW-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign point[AXIS_X] = s_axis_tdata[31:0];
  assign point[AXIS_Y] = s_axis_tdata[63:32];
  assign point[AXIS_Z] = s_axis_tdata[95:64];

  pbc_dist u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .box_i       (box_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_point_i  (point),
    .out_valid_o (d_valid),
    .out_ready_i (d_ready),
    .out_data_o  (d_data)
  );

  pbc_axis u_axis (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (d_valid),
    .in_ready_o  (d_ready),
    .in_data_i   (d_data),
    .out_valid_o (a_valid),
    .out_ready_i (a_ready),
    .out_data_o  (a_data)
  );

  pbc_select u_select (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .box_i       (box_q),
    .in_valid_i  (a_valid),
    .in_ready_o  (a_ready),
    .in_data_i   (a_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res)
  );

  assign m_axis_tdata = {1'b0,
                         res.normal[AXIS_Z], res.normal[AXIS_Y], res.normal[AXIS_X],
                         res.contact[AXIS_Z], res.contact[AXIS_Y], res.contact[AXIS_X],
                         res.hit};

endmodule

FILE: rtl/pbc_checker.sv
// ----------------------------------------------------------------------------
// pbc_checker
// Port-level checks of the point-in-box contact block, bound to the top.
// ----------------------------------------------------------------------------
`include "point_box_contact_defines.svh"

module pbc_checker import pbc_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata
);

  logic       hit;
  logic [1:0] nx, ny, nz;
  logic [2:0] face_set;
  logic       norm_ok;

  assign hit      = m_axis_tdata[0];
  assign nx       = m_axis_tdata[98:97];
  assign ny       = m_axis_tdata[100:99];
  assign nz       = m_axis_tdata[102:101];
  assign face_set = {nx != NORM_ZERO, ny != NORM_ZERO, nz != NORM_ZERO};
  assign norm_ok  = (nx inside {NORM_ZERO, NORM_POS, NORM_NEG}) &&
                    (ny inside {NORM_ZERO, NORM_POS, NORM_NEG}) &&
                    (nz inside {NORM_ZERO, NORM_POS, NORM_NEG});

  // a waiting result stays offered
  `PBC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // a miss carries zero contact and normal
  `PBC_ASSERT_NOW(a_miss_zero, clk_i, rst_ni, m_axis_tvalid && !hit, m_axis_tdata[102:1] == '0)

  // a hit has exactly one face normal
  `PBC_ASSERT_NOW(a_hit_one_face, clk_i, rst_ni, m_axis_tvalid && hit, $countones(face_set) == 1)

  // normal components are only -1, 0 or +1
  `PBC_ASSERT_NOW(a_norm_code, clk_i, rst_ni, m_axis_tvalid, norm_ok)

endmodule

bind point_box_contact pbc_checker u_pbc_checker (.*);
